[hdl/fasc_pkg.sv]
`default_nettype none
package fasc_pkg;

  localparam int FRAME_W    = 10;
  localparam int ADDR_W     = 48;
  localparam int OWNER_W    = 8;
  localparam int FRAME_SPACE = 1 << FRAME_W;
  localparam int FRAMES_DEF = 1024;

  typedef logic [FRAME_W-1:0] frame_t;

  // Actions.
  localparam logic [2:0] ACT_ALLOC = 3'd0;
  localparam logic [2:0] ACT_FREE  = 3'd1;
  localparam logic [2:0] ACT_PIN   = 3'd2;
  localparam logic [2:0] ACT_UNPIN = 3'd3;
  localparam logic [2:0] ACT_REF   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFRAME = 2'd1;
  localparam logic [1:0] ST_PINLIM  = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Per-frame flags: bit 0 referenced, bit 1 pinned, bits 3..2 list.
  localparam int FL_REF = 0;
  localparam int FL_PIN = 1;
  localparam logic [1:0] LIST_NONE  = 2'd0;
  localparam logic [1:0] LIST_FREE  = 2'd1;
  localparam logic [1:0] LIST_ALLOC = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    frame_t             frame;
    logic [ADDR_W-1:0]  page_addr;
    logic [OWNER_W-1:0] owner;
  } in_t;

  typedef struct packed {
    frame_t             result_frame;
    logic [1:0]         status;
    logic               evicted;
    frame_t             evicted_frame;
    logic [ADDR_W-1:0]  evicted_addr;
    logic [OWNER_W-1:0] evicted_owner;
  } out_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_ACCEPT,
    CMD_FREE_POP,
    CMD_FREE_UNLINK,
    CMD_FRESH,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_FAIL,
    CMD_APPEND1,
    CMD_APPEND2,
    CMD_CHECK,
    CMD_PREPEND1,
    CMD_PREPEND2
  } cmd_e;

  typedef struct packed {
    logic [2:0] action;
    logic       clear_done;
    logic       free_empty;
    logic       fresh_ok;
    logic       alloc_empty;
    logic       victim;
    logic       scan_fail;
    logic       check_ok;
  } dp_status_t;

endpackage
`default_nettype wire

[hdl/fasc_datapath.sv]
`default_nettype none
module fasc_datapath
  import fasc_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_e        cmd_i,
  input  in_t         item_i,
  input  wire         cfg_we_i,
  input  frame_t      cfg_wdata_i,
  output dp_status_t  status_o,
  output out_t        result_o
);

  localparam int DEPTH = (FRAMES < FRAME_SPACE) ? FRAMES : FRAME_SPACE;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] idx(input frame_t f);
    return f[AW-1:0];
  endfunction

  frame_t             next_mem  [DEPTH];
  frame_t             prev_mem  [DEPTH];
  logic [3:0]         flag_mem  [DEPTH];
  logic [ADDR_W-1:0]  addr_mem  [DEPTH];
  logic [OWNER_W-1:0] owner_mem [DEPTH];

  frame_t free_head_q, free_tail_q, alloc_head_q, alloc_tail_q;
  logic [FRAME_W:0] fresh_q, pinned_q;
  frame_t limit_q;
  logic [AW-1:0] clr_q;
  logic pass_q;

  in_t    item_q;
  out_t   res_q;
  frame_t f_q, p_q, cur_q;
  logic   ref_q;

  frame_t             rd_next_q, rd_prev_q;
  logic [3:0]         rd_flags_q;
  logic [ADDR_W-1:0]  rd_addr_q;
  logic [OWNER_W-1:0] rd_owner_q;

  frame_t raddr;
  logic nx_we, pv_we, fl_we, pl_we;
  frame_t nx_wa, nx_wd, pv_wa, pv_wd, fl_wa, pl_wa;
  logic [3:0] fl_wd;

  logic check_ok, victim, list_end, scan_fail, fresh_ok;
  frame_t nxt_cur;
  logic [FRAME_W:0] pinned_pin;

  assign check_ok = (item_q.frame != '0) && (32'(item_q.frame) < FRAMES)
                    && (rd_flags_q[3:2] == LIST_ALLOC);
  assign victim     = !rd_flags_q[FL_PIN] && !rd_flags_q[FL_REF];
  assign list_end   = (rd_next_q == '0);
  assign scan_fail  = !victim && list_end && pass_q;
  assign nxt_cur    = list_end ? alloc_head_q : rd_next_q;
  assign fresh_ok   = (fresh_q <= {1'b0, limit_q}) && (32'(fresh_q) < FRAMES);
  assign pinned_pin = pinned_q + {{FRAME_W{1'b0}}, !rd_flags_q[FL_PIN]};

  assign status_o = '{
    action:      item_q.action,
    clear_done:  (clr_q == AW'(DEPTH - 1)),
    free_empty:  (free_head_q == '0),
    fresh_ok:    fresh_ok,
    alloc_empty: (alloc_head_q == '0),
    victim:      victim,
    scan_fail:   scan_fail,
    check_ok:    check_ok
  };
  assign result_o = res_q;

  always_comb begin
    raddr = item_q.frame;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0;
    pl_we = 1'b0; pl_wa = f_q;
    unique case (cmd_i)
      CMD_CLEAR: begin
        fl_we = 1'b1;
        fl_wa = frame_t'(clr_q);
      end
      CMD_ACCEPT:     raddr = item_i.frame;
      CMD_FREE_POP:   raddr = free_head_q;
      CMD_SCAN_START: raddr = alloc_head_q;
      CMD_FREE_UNLINK: begin
        pv_we = (rd_next_q != '0);
        pv_wa = rd_next_q;
      end
      CMD_SCAN_STEP: begin
        raddr = nxt_cur;
        if (victim) begin
          nx_we = (rd_prev_q != '0);
          nx_wa = rd_prev_q;
          nx_wd = rd_next_q;
          pv_we = (rd_next_q != '0);
          pv_wa = rd_next_q;
          pv_wd = rd_prev_q;
        end else if (!rd_flags_q[FL_PIN]) begin
          fl_we = 1'b1;
          fl_wa = cur_q;
          fl_wd = rd_flags_q & ~(4'b1 << FL_REF);
        end
      end
      CMD_APPEND1: begin
        nx_we = 1'b1; nx_wa = f_q;
        pv_we = 1'b1; pv_wa = f_q; pv_wd = alloc_tail_q;
        fl_we = 1'b1; fl_wa = f_q; fl_wd = {LIST_ALLOC, 1'b0, 1'b1};
        pl_we = 1'b1;
      end
      CMD_APPEND2: begin
        nx_we = (p_q != '0); nx_wa = p_q; nx_wd = f_q;
      end
      CMD_CHECK: begin
        if (check_ok) begin
          fl_wa = item_q.frame;
          unique case (item_q.action)
            ACT_FREE: begin
              nx_we = (rd_prev_q != '0);
              nx_wa = rd_prev_q;
              nx_wd = rd_next_q;
              pv_we = (rd_next_q != '0);
              pv_wa = rd_next_q;
              pv_wd = rd_prev_q;
            end
            ACT_PIN: begin
              fl_we = 1'b1; fl_wd = rd_flags_q | (4'b1 << FL_PIN);
            end
            ACT_UNPIN: begin
              fl_we = 1'b1; fl_wd = rd_flags_q & ~(4'b1 << FL_PIN);
            end
            ACT_REF: begin
              fl_we = 1'b1; fl_wd = rd_flags_q | (4'b1 << FL_REF);
            end
            default: ;
          endcase
        end
      end
      CMD_PREPEND1: begin
        nx_we = 1'b1; nx_wa = f_q; nx_wd = free_head_q;
        pv_we = 1'b1; pv_wa = f_q;
        fl_we = 1'b1; fl_wa = f_q; fl_wd = {LIST_FREE, 1'b0, ref_q};
      end
      CMD_PREPEND2: begin
        pv_we = (p_q != '0); pv_wa = p_q; pv_wd = f_q;
      end
      default: ;
    endcase
  end

  // Flag store forwards a same-cycle write so a rescan sees cleared bits.
  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[idx(nx_wa)] <= nx_wd;
    if (pv_we) prev_mem[idx(pv_wa)] <= pv_wd;
    if (fl_we) flag_mem[idx(fl_wa)] <= fl_wd;
    if (pl_we) begin
      addr_mem[idx(pl_wa)]  <= item_q.page_addr;
      owner_mem[idx(pl_wa)] <= item_q.owner;
    end
    rd_next_q  <= next_mem[idx(raddr)];
    rd_prev_q  <= prev_mem[idx(raddr)];
    rd_flags_q <= (fl_we && idx(fl_wa) == idx(raddr)) ? fl_wd : flag_mem[idx(raddr)];
    rd_addr_q  <= addr_mem[idx(raddr)];
    rd_owner_q <= owner_mem[idx(raddr)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      free_tail_q  <= '0;
      alloc_head_q <= '0;
      alloc_tail_q <= '0;
      fresh_q      <= (FRAME_W+1)'(1);
      pinned_q     <= '0;
      limit_q      <= frame_t'(FRAME_SPACE - 1);
      clr_q        <= '0;
      pass_q       <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      unique case (cmd_i)
        CMD_CLEAR: clr_q <= clr_q + AW'(1);
        CMD_FREE_UNLINK: begin
          free_head_q <= rd_next_q;
          if (rd_next_q == '0) free_tail_q <= '0;
        end
        CMD_FRESH:      fresh_q <= fresh_q + (FRAME_W+1)'(1);
        CMD_SCAN_START: pass_q <= 1'b0;
        CMD_SCAN_STEP: begin
          if (victim) begin
            if (rd_prev_q == '0) alloc_head_q <= rd_next_q;
            if (rd_next_q == '0) alloc_tail_q <= rd_prev_q;
          end else if (list_end) begin
            pass_q <= 1'b1;
          end
        end
        CMD_APPEND1: begin
          alloc_tail_q <= f_q;
          if (alloc_tail_q == '0) alloc_head_q <= f_q;
        end
        CMD_CHECK: begin
          if (check_ok) begin
            if ((item_q.action == ACT_FREE || item_q.action == ACT_UNPIN)
                && rd_flags_q[FL_PIN] && pinned_q != '0) begin
              pinned_q <= pinned_q - (FRAME_W+1)'(1);
            end
            if (item_q.action == ACT_PIN) pinned_q <= pinned_pin;
            if (item_q.action == ACT_FREE) begin
              if (rd_prev_q == '0) alloc_head_q <= rd_next_q;
              if (rd_next_q == '0) alloc_tail_q <= rd_prev_q;
            end
          end
        end
        CMD_PREPEND1: begin
          free_head_q <= f_q;
          if (free_head_q == '0) free_tail_q <= f_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_ACCEPT: begin
        item_q <= item_i;
        res_q  <= '0;
      end
      CMD_FREE_POP: f_q <= free_head_q;
      CMD_FRESH:    f_q <= fresh_q[FRAME_W-1:0];
      CMD_SCAN_START: cur_q <= alloc_head_q;
      CMD_SCAN_STEP: begin
        cur_q <= nxt_cur;
        if (victim) begin
          f_q                 <= cur_q;
          res_q.evicted       <= 1'b1;
          res_q.evicted_frame <= cur_q;
          res_q.evicted_addr  <= rd_addr_q;
          res_q.evicted_owner <= rd_owner_q;
        end else if (scan_fail) begin
          res_q.status <= ST_NOFRAME;
        end
      end
      CMD_FAIL: res_q.status <= ST_NOFRAME;
      CMD_APPEND1: begin
        p_q                <= alloc_tail_q;
        res_q.result_frame <= f_q;
      end
      CMD_CHECK: begin
        f_q   <= item_q.frame;
        ref_q <= rd_flags_q[FL_REF];
        if (!check_ok) begin
          res_q.status <= ST_INVALID;
        end else if (item_q.action == ACT_PIN && limit_q != '0
                     && pinned_pin >= {1'b0, limit_q}) begin
          res_q.status <= ST_PINLIM;
        end
      end
      CMD_PREPEND1: p_q <= free_head_q;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_alloc_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alloc_head_q == '0) == (alloc_tail_q == '0))
    else $error("allocated list head and tail disagree on emptiness");
  a_free_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q == '0) == (free_tail_q == '0))
    else $error("free list head and tail disagree on emptiness");
`endif

endmodule
`default_nettype wire

[hdl/fasc_controller.sv]
`default_nettype none
module fasc_controller
  import fasc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  dp_status_t status_i,
  output cmd_e       cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_FUNLINK  = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_APPEND1  = 4'd5;
  localparam logic [3:0] S_APPEND2  = 4'd6;
  localparam logic [3:0] S_PREPEND1 = 4'd7;
  localparam logic [3:0] S_PREPEND2 = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_q, state_d;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (status_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = CMD_ACCEPT;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.action == ACT_ALLOC) begin
          priority if (!status_i.free_empty) begin
            cmd_o   = CMD_FREE_POP;
            state_d = S_FUNLINK;
          end else if (status_i.fresh_ok) begin
            cmd_o   = CMD_FRESH;
            state_d = S_APPEND1;
          end else if (status_i.alloc_empty) begin
            cmd_o   = CMD_FAIL;
            state_d = S_DONE;
          end else begin
            cmd_o   = CMD_SCAN_START;
            state_d = S_SCAN;
          end
        end else if (status_i.action == ACT_FREE || status_i.action == ACT_PIN ||
                     status_i.action == ACT_UNPIN || status_i.action == ACT_REF) begin
          cmd_o   = CMD_CHECK;
          state_d = (status_i.action == ACT_FREE && status_i.check_ok) ?
                    S_PREPEND1 : S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FUNLINK: begin
        cmd_o   = CMD_FREE_UNLINK;
        state_d = S_APPEND1;
      end
      S_SCAN: begin
        cmd_o = CMD_SCAN_STEP;
        if (status_i.victim) state_d = S_APPEND1;
        else if (status_i.scan_fail) state_d = S_DONE;
      end
      S_APPEND1: begin
        cmd_o   = CMD_APPEND1;
        state_d = S_APPEND2;
      end
      S_APPEND2: begin
        cmd_o   = CMD_APPEND2;
        state_d = S_DONE;
      end
      S_PREPEND1: begin
        cmd_o   = CMD_PREPEND1;
        state_d = S_PREPEND2;
      end
      S_PREPEND2: begin
        cmd_o   = CMD_PREPEND2;
        state_d = S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_DISPATCH))
    else $error("accepted word did not reach dispatch");
`endif

endmodule
`default_nettype wire

[hdl/frame_allocator_second_chance_unit.sv]
`default_nettype none
// Second-chance frame allocator for frames 1..frame_limit that lie below FRAMES.
// A word (action, frame, page_addr, owner) is taken at a rising edge with
// start_i high and busy_o low. Exactly one result word follows on result_o,
// marked by done_o for a single cycle; the receiver must take it then, since
// there is no way to hold it off. busy_o is high from the accepting edge
// through the strobe cycle, so one word is in flight at a time and the next
// word can be taken at the edge that ends the cycle after the strobe.
// Pin, unpin, reference, unknown actions, rejected targets and an allocate
// with both lists empty and no never-used frame left finish after dispatch;
// free also moves the frame from the allocated list to the free list;
// allocate takes a frame from the free list, else a never-used frame, else
// a victim found by walking the allocated list (at most two passes over
// the list), and appends it to the allocated list; a search that finds no
// victim reports ST_NOFRAME. The link and flag memories each take one write
// and one registered read per cycle.
// After reset the block clears the flag memory one entry per cycle, all
// min(FRAMES, 1024) entries, with busy_o high. frame_limit is written
// through cfg_we_i and cfg_wdata_i and resets to 1023; write it only while
// the block is idle, which the block itself does not enforce.
module frame_allocator_second_chance_unit
  import fasc_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    start_i,
  input  in_t    item_i,
  output logic   busy_o,
  output logic   done_o,
  output out_t   result_o,
  input  wire    cfg_we_i,
  input  frame_t cfg_wdata_i
);

  // The controller sequences list operations; the datapath owns the
  // memories, list heads and tails, and the counters.
  cmd_e       cmd;
  dp_status_t dp_status;

  fasc_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  fasc_datapath #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (dp_status),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire
